// ===== rtl/core/dhkt_pkg.sv =====
// Shared types and constants of the double-hashed key table.
// No dependencies; every other file of the block but dhkt_ram imports this package.
package dhkt_pkg;

  localparam int SLOT_CAPACITY = 1024;
  localparam int KEY_BYTES     = 8;
  localparam int IDX_W         = $clog2(SLOT_CAPACITY);
  localparam int HASH_W        = 32;
  localparam int KEY_W         = 8 * KEY_BYTES;
  localparam int LEN_W         = 4;
  localparam int VAL_W         = 32;
  localparam int LIVE_W        = IDX_W + 1;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [2:0] {
    OP_FIND    = 3'd0,
    OP_ENTER   = 3'd1,
    OP_REPLACE = 3'd2,
    OP_RELEASE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef struct packed {
    mark_t              mark;
    logic [HASH_W-1:0]  tag;
    logic [LEN_W-1:0]   key_len;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/dhkt_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on dhkt_pkg for field widths.
interface dhkt_in_if;
  import dhkt_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [KEY_W-1:0]  key_bytes;
  logic [LEN_W-1:0]  key_length;
  logic [VAL_W-1:0]  value;
  modport source (output valid, op, key_bytes, key_length, value, input ready);
  modport sink   (input valid, op, key_bytes, key_length, value, output ready);
endinterface

interface dhkt_out_if;
  import dhkt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [IDX_W-1:0]  slot;
  logic [VAL_W-1:0]  stored_value;
  modport source (output valid, status, slot, stored_value, input ready);
  modport sink   (input valid, status, slot, stored_value, output ready);
endinterface

// ===== rtl/core/dhkt_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module dhkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/dhkt_div.sv =====
// Bit-serial restoring remainder unit: hash word modulo a slot-sized divisor.
// Depends on dhkt_pkg. One quotient bit per cycle.
module dhkt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dhkt_pkg::HASH_W-1:0] dividend,
  input  logic [dhkt_pkg::IDX_W-1:0]  divisor,
  output logic                      done,
  output logic [dhkt_pkg::IDX_W-1:0]  remainder
);
  import dhkt_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HASH_W-1:0] dvd_r, dvd_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  dsr_r, dsr_nxt;
  logic [IDX_W:0]    trial;
  logic [IDX_W:0]    shifted;

  always_comb begin
    shifted = {rem_r, dvd_r[HASH_W-1]};
    if (shifted >= {1'b0, dsr_r}) begin
      trial = shifted - {1'b0, dsr_r};
    end else begin
      trial = shifted;
    end
  end

  assign remainder = trial[IDX_W-1:0];
  assign done      = busy_r && (cnt_r == CNT_W'(HASH_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[HASH_W-2:0], 1'b0};
      rem_nxt = trial[IDX_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end
endmodule

// ===== rtl/core/double_hash_key_table.sv =====
// Double-hashed key/value table, top level.
// Depends on dhkt_pkg, dhkt_if, dhkt_ram and dhkt_div.
//
// Requests arrive on in_if (find, enter, replace, release, clear) and each
// produces exactly one result item on out_if. The slot count is set by the
// APB-style register table_size at byte address 0; the user must write it
// only while the block is idle, as the block itself does not enforce this.
//
// One request is handled at a time. A key of L bytes is hashed byte by byte,
// then the shared remainder unit runs twice (home slot, probe step). Each
// probe of the slot RAM passes through a read state and a check state.
//
// After reset the block sweeps all 1024 RAM entries to empty, one a cycle,
// and holds in_if.ready low for the whole sweep. A clear request that finds
// live entries runs the same sweep after its result item is handed over.
// A finished result waits in the output register while the receiver stalls;
// the next request is still accepted, and its result waits until that
// register is free.
module double_hash_key_table (
  input  logic                              clk,
  input  logic                              rst_n,
  dhkt_in_if.sink                           in_if,
  dhkt_out_if.source                        out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dhkt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [dhkt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [dhkt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import dhkt_pkg::*;

  typedef enum logic [7:0] {
    S_SWEEP = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HASH  = 8'b0000_0100,
    S_MOD1  = 8'b0000_1000,
    S_MOD2  = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_CHK   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   table_size_r;
  logic [IDX_W:0]     sweep_r, sweep_nxt;
  logic               sweep_after_r, sweep_after_nxt;
  logic [LIVE_W-1:0]  live_r, live_nxt;

  op_t                op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [IDX_W-1:0]   size_r, size_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   home_r, home_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  status_t            res_status_r, res_status_nxt;
  logic [IDX_W-1:0]   res_slot_r, res_slot_nxt;
  logic [VAL_W-1:0]   res_val_r, res_val_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_slot_r, out_slot_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;

  logic               in_acc;
  logic               out_free;
  logic [LEN_W-1:0]   in_len;
  logic [KEY_W-1:0]   in_key;
  logic [IDX_W-1:0]   in_size;
  logic [2:0]         byte_sel;
  logic [7:0]         cur_byte;
  logic [HASH_W-1:0]  hash_fin;
  logic [IDX_W:0]     idx_wrap;
  logic [IDX_W-1:0]   idx_next;

  logic               div_start;
  logic [HASH_W-1:0]  div_dividend;
  logic [IDX_W-1:0]   div_divisor;
  logic               div_done;
  logic [IDX_W-1:0]   div_rem;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic               key_match;

  // Configuration port: a single register, always ready.
  assign pready = 1'b1;
  assign prdata = CFG_DATA_W'(table_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= IDX_W'(1021);
    end else if (psel && penable && pwrite && pready && (paddr == '0)) begin
      table_size_r <= pwdata[IDX_W-1:0];
    end
  end

  // The request is taken whenever the sequencer is idle.
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // Lengths above the key width count as the full width; bytes at or above
  // the length are dropped before hashing and comparing.
  always_comb begin
    in_len = (in_if.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                    : in_if.key_length;
    for (int b = 0; b < KEY_BYTES; b++) begin
      in_key[8*b +: 8] = (LEN_W'(b) < in_len) ? in_if.key_bytes[8*b +: 8] : 8'h00;
    end
    if (table_size_r < IDX_W'(3)) begin
      in_size = IDX_W'(3);
    end else if ({1'b0, table_size_r} > (IDX_W+1)'(SLOT_CAPACITY - 1)) begin
      in_size = IDX_W'(SLOT_CAPACITY - 1);
    end else begin
      in_size = table_size_r;
    end
  end

  assign byte_sel = 3'(cnt_r - 1'b1);
  assign cur_byte = key_r[8*byte_sel +: 8];
  assign hash_fin = (hash_r == '0) ? HASH_W'(1) : hash_r;

  // Probes walk downward and wrap within 1..size.
  always_comb begin
    if (idx_r <= step_r) begin
      idx_wrap = {1'b0, size_r} + {1'b0, idx_r} - {1'b0, step_r};
    end else begin
      idx_wrap = {1'b0, idx_r} - {1'b0, step_r};
    end
    idx_next = idx_wrap[IDX_W-1:0];
  end

  assign key_match = (ram_rdata.tag == hash_r) && (ram_rdata.key_len == len_r) &&
                     (ram_rdata.key == key_r);

  assign div_dividend = hash_fin;

  always_comb begin
    state_nxt       = state_r;
    sweep_nxt       = sweep_r;
    sweep_after_nxt = sweep_after_r;
    live_nxt        = live_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    len_nxt         = len_r;
    val_nxt         = val_r;
    size_nxt        = size_r;
    hash_nxt        = hash_r;
    cnt_nxt         = cnt_r;
    home_nxt        = home_r;
    step_nxt        = step_r;
    idx_nxt         = idx_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_val_nxt     = res_val_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_val_nxt     = out_val_r;
    div_start       = 1'b0;
    div_divisor     = size_r;
    ram_we          = 1'b0;
    ram_addr        = idx_r;
    ram_wdata       = ram_rdata;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_r[IDX_W-1:0];
        ram_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == (IDX_W+1)'(SLOT_CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = op_t'(in_if.op);
          key_nxt      = in_key;
          len_nxt      = in_len;
          val_nxt      = in_if.value;
          size_nxt     = in_size;
          hash_nxt     = HASH_W'(in_len);
          cnt_nxt      = in_len;
          res_slot_nxt = '0;
          res_val_nxt  = '0;
          sweep_nxt    = '0;
          sweep_after_nxt = 1'b0;
          case (in_if.op) inside
            OP_CLEAR: begin
              // An empty table keeps its tombstones.
              res_status_nxt = ST_OK;
              state_nxt      = S_EMIT;
              if (live_r != '0) begin
                live_nxt        = '0;
                sweep_after_nxt = 1'b1;
              end
            end
            OP_FIND, OP_ENTER, OP_REPLACE, OP_RELEASE: begin
              state_nxt = S_HASH;
            end
            default: begin
              res_status_nxt = ST_MISS;
              state_nxt      = S_EMIT;
            end
          endcase
        end
      end
      S_HASH: begin
        if (cnt_r == '0) begin
          hash_nxt  = hash_fin;
          div_start = 1'b1;
          state_nxt = S_MOD1;
        end else begin
          hash_nxt = {hash_r[HASH_W-5:0], 4'h0} + HASH_W'(cur_byte);
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      S_MOD1: begin
        if (div_done) begin
          home_nxt    = div_rem + 1'b1;
          div_start   = 1'b1;
          div_divisor = size_r - IDX_W'(2);
          state_nxt   = S_MOD2;
        end
      end
      S_MOD2: begin
        div_divisor = size_r - IDX_W'(2);
        if (div_done) begin
          step_nxt  = div_rem + 1'b1;
          idx_nxt   = home_r;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt      = S_EMIT;
        res_status_nxt = ST_OK;
        res_slot_nxt   = idx_r;
        if (ram_rdata.mark == MARK_EMPTY) begin
          if (op_r != OP_ENTER) begin
            res_status_nxt = ST_MISS;
            res_slot_nxt   = '0;
          end else if (live_r >= {1'b0, size_r}) begin
            res_status_nxt = ST_FULL;
            res_slot_nxt   = '0;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{mark: MARK_LIVE, tag: hash_r, key_len: len_r,
                          key: key_r, value: val_r};
            live_nxt    = live_r + 1'b1;
            res_val_nxt = val_r;
          end
        end else if ((ram_rdata.mark == MARK_LIVE) && key_match) begin
          res_val_nxt = ram_rdata.value;
          if (op_r == OP_REPLACE) begin
            ram_we          = 1'b1;
            ram_wdata.value = val_r;
            res_val_nxt     = val_r;
          end else if (op_r == OP_RELEASE) begin
            ram_we         = 1'b1;
            ram_wdata.mark = MARK_TOMB;
            live_nxt       = live_r - 1'b1;
          end
        end else if ((ram_rdata.mark == MARK_TOMB) && (op_r == OP_ENTER)) begin
          // Enter reuses the first tombstone on its probe path.
          ram_we    = 1'b1;
          ram_wdata = '{mark: MARK_LIVE, tag: hash_r, key_len: len_r,
                        key: key_r, value: val_r};
          live_nxt    = live_r + 1'b1;
          res_val_nxt = val_r;
        end else if (idx_next == home_r) begin
          res_status_nxt = (op_r == OP_ENTER) ? ST_FULL : ST_MISS;
          res_slot_nxt   = '0;
        end else begin
          idx_nxt   = idx_next;
          state_nxt = S_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_val_nxt    = res_val_r;
          state_nxt      = sweep_after_r ? S_SWEEP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      sweep_r       <= '0;
      sweep_after_r <= 1'b0;
      live_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_r       <= sweep_nxt;
      sweep_after_r <= sweep_after_nxt;
      live_r        <= live_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    val_r        <= val_nxt;
    size_r       <= size_nxt;
    hash_r       <= hash_nxt;
    cnt_r        <= cnt_nxt;
    home_r       <= home_nxt;
    step_r       <= step_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_val_r    <= out_val_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.slot         = out_slot_r;
  assign out_if.stored_value = out_val_r;

  dhkt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  dhkt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );
endmodule

// ===== test/double_hash_key_table_checker.sv =====
// Checker for the double-hashed key table: watches the request, result and
// register ports, predicts every result item and compares it field by field.
// Depends on dhkt_pkg and the channel interfaces in dhkt_if.
module double_hash_key_table_checker
  import dhkt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dhkt_in_if                    in_ch,
  dhkt_out_if                   out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    errors,
  output int                    pending
);

  localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_SIZE = '0;

  typedef struct {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic [VAL_W-1:0] stored_value;
  } answer_t;

  mark_t             mark_mem [SLOT_CAPACITY];
  logic [HASH_W-1:0] tag_mem  [SLOT_CAPACITY];
  logic [KEY_W-1:0]  key_mem  [SLOT_CAPACITY];
  logic [LEN_W-1:0]  len_mem  [SLOT_CAPACITY];
  logic [VAL_W-1:0]  val_mem  [SLOT_CAPACITY];
  int unsigned       live_entries;
  logic [9:0]        size_reg;
  answer_t           answers_due [$];
  int                error_count;

  function automatic answer_t make_answer(status_t st, int unsigned slot,
                                          logic [VAL_W-1:0] v);
    answer_t a;
    a.status       = st;
    a.slot         = slot[IDX_W-1:0];
    a.stored_value = v;
    return a;
  endfunction

  // Runs one request against the shadow table and returns its answer.
  function automatic answer_t serve_request(logic [2:0] op, logic [KEY_W-1:0] key,
                                            logic [LEN_W-1:0] len_in,
                                            logic [VAL_W-1:0] v);
    int unsigned size, len, h, home, stride, idx;
    if (op == OP_CLEAR) begin
      if (live_entries != 0) begin
        for (int i = 0; i < SLOT_CAPACITY; i++) begin
          mark_mem[i] = MARK_EMPTY;
          tag_mem[i]  = '0;
        end
        live_entries = 0;
      end
      return make_answer(ST_OK, 0, '0);
    end
    if (op > OP_CLEAR) return make_answer(ST_MISS, 0, '0);

    size = size_reg;
    if (size < 3) size = 3;
    if (size > SLOT_CAPACITY - 1) size = SLOT_CAPACITY - 1;
    len = (len_in > KEY_BYTES) ? KEY_BYTES : len_in;
    if (len < 8) key &= (64'd1 << (8 * len)) - 64'd1;

    h = len;
    for (int c = len; c > 0; c--) h = (h << 4) + key[8*(c-1) +: 8];
    if (h == 0) h = 1;
    home   = h % size + 1;
    stride = 1 + h % (size - 2);
    idx    = home;

    while (mark_mem[idx] != MARK_EMPTY) begin
      if (mark_mem[idx] == MARK_LIVE && tag_mem[idx] == h &&
          len_mem[idx] == len && key_mem[idx] == key) begin
        if (op == OP_REPLACE) begin
          val_mem[idx] = v;
        end else if (op == OP_RELEASE) begin
          mark_mem[idx] = MARK_TOMB;
          live_entries--;
        end
        return make_answer(ST_OK, idx, val_mem[idx]);
      end
      if (mark_mem[idx] == MARK_TOMB && op == OP_ENTER) begin
        mark_mem[idx] = MARK_LIVE;
        tag_mem[idx]  = h;
        key_mem[idx]  = key;
        len_mem[idx]  = len;
        val_mem[idx]  = v;
        live_entries++;
        return make_answer(ST_OK, idx, v);
      end
      idx = (idx <= stride) ? size + idx - stride : idx - stride;
      if (idx == home)
        return make_answer(op == OP_ENTER ? ST_FULL : ST_MISS, 0, '0);
    end

    if (op == OP_ENTER) begin
      if (live_entries >= size) return make_answer(ST_FULL, 0, '0);
      mark_mem[idx] = MARK_LIVE;
      tag_mem[idx]  = h;
      key_mem[idx]  = key;
      len_mem[idx]  = len;
      val_mem[idx]  = v;
      live_entries++;
      return make_answer(ST_OK, idx, v);
    end
    return make_answer(ST_MISS, 0, '0);
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_CAPACITY; i++) begin
        mark_mem[i] = MARK_EMPTY;
        tag_mem[i]  = '0;
      end
      live_entries = 0;
      size_reg     = 10'd1021;
      answers_due.delete();
      error_count  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TABLE_SIZE)
        size_reg = pwdata[9:0];
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          $error("result item with no request waiting: status %0d slot %0d",
                 out_ch.status, out_ch.slot);
          error_count++;
        end else begin
          want = answers_due.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            error_count++;
          end
          if (out_ch.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_ch.slot);
            error_count++;
          end
          if (out_ch.stored_value !== want.stored_value) begin
            $error("stored_value: expected %h, got %h", want.stored_value,
                   out_ch.stored_value);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        answers_due.push_back(serve_request(in_ch.op, in_ch.key_bytes,
                                            in_ch.key_length, in_ch.value));
    end
    errors  <= error_count;
    pending <= answers_due.size();
  end

endmodule

// ===== test/double_hash_key_table_tb.sv =====
// Top of the double-hashed key table testbench: clock, reset, request and
// register stimulus, receiver stalls and the verdict.
// Depends on dhkt_pkg, dhkt_if, the block itself and the checker.
module double_hash_key_table_tb;
  import dhkt_pkg::*;

  // Run limit in cycles; far above the slowest correct run of this stimulus.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Quiet time before a register write: covers a post-clear sweep of the
  // whole RAM plus one request's worth of latency.
  localparam int SETTLE_CYCLES = 1200;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int POOL_MAX = 24;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_SIZE = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  int errors, pending;
  int cycles = 0;
  int send_idle = 0;       // percent of cycles the sender leaves idle
  int recv_idle = 0;       // percent of cycles the receiver stalls
  int hold_asks = 0;       // bumped to request one long receiver hold-off
  int hold_seen = 0;
  int hold_left = 0;
  bit offering = 1'b0;     // valid is currently high

  logic [KEY_W-1:0] key_pool [POOL_MAX];
  logic [LEN_W-1:0] len_pool [POOL_MAX];
  int pool_n;

  dhkt_in_if  in_ch ();
  dhkt_out_if out_ch ();

  double_hash_key_table i_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  double_hash_key_table_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  always #2 clk = ~clk;

  // The cycle counter doubles as the watchdog for every wait in the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_hash_key_table_tb: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks
  // for one. The hold-off is counted here so that only this process drives
  // ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= 500;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one item and waits for its handshake. The sender then idles for
  // a random stretch, lowering valid only when a gap really follows.
  task automatic send_item(logic [2:0] op, logic [KEY_W-1:0] key,
                           logic [LEN_W-1:0] len, logic [VAL_W-1:0] v);
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.key_bytes <= key;
    in_ch.key_length <= len;
    in_ch.value <= v;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  // Stops offering and waits until every expected result item has arrived.
  task automatic drain();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle. The random upper bits check
  // that only the low ten bits of table_size count.
  task automatic write_table_size(logic [9:0] size);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_TABLE_SIZE;
    pwdata <= {22'($urandom_range(4194303)), size};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] key, int len);
    if (len >= 8) return key;
    return key & ((64'd1 << (8 * len)) - 64'd1);
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    return {$urandom(), $urandom()};
  endfunction

  // Fresh key pool for one phase: a pool larger than most small tables,
  // so enters hit the full and wrap cases while finds mostly hit.
  task automatic fill_pool(int n);
    int len;
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
      len_pool[i] = LEN_W'(len);
      // Now and then the bytes beyond the length are left as garbage.
      key_pool[i] = ($urandom_range(7) == 0) ? any_key() : trim_key(any_key(), len);
    end
  endtask

  task automatic random_item();
    int r, k;
    r = $urandom_range(99);
    k = $urandom_range(pool_n - 1);
    if (r < 35)
      send_item(OP_ENTER, key_pool[k], len_pool[k], $urandom());
    else if (r < 55)
      send_item(OP_FIND, key_pool[k], len_pool[k], $urandom());
    else if (r < 70)
      send_item(OP_REPLACE, key_pool[k], len_pool[k], $urandom());
    else if (r < 88)
      send_item(OP_RELEASE, key_pool[k], len_pool[k], $urandom());
    else if (r < 96)
      send_item(3'($urandom_range(3)), any_key(), LEN_W'($urandom_range(15)),
                $urandom());
    else if (r < 98)
      send_item(OP_CLEAR, any_key(), LEN_W'($urandom_range(15)), $urandom());
    else
      send_item(3'($urandom_range(7, 5)), any_key(), LEN_W'($urandom_range(15)),
                $urandom());
  endtask

  // Table sizes per phase: prime sizes, the extremes, and values that the
  // block clamps into range.
  logic [9:0] phase_size [10] = '{10'd1021, 10'd3, 10'd0, 10'd13, 10'd1023,
                                   10'd7, 10'd2, 10'd31, 10'd1022, 10'd5};

  initial begin
    localparam logic [KEY_W-1:0] ONES_KEY = 64'h0F0F_0F0F_0F0F_0F0F;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_FIND;
    in_ch.key_bytes <= '0;
    in_ch.key_length <= '0;
    in_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size. Sender and receiver both idle at
    // random so the first items land on a busy block too.
    send_idle = 25;
    recv_idle = 86;
    send_item(OP_FIND, 64'h0000_0000_0041_4243, 4'd3, 32'h0);       // miss, empty table
    send_item(OP_CLEAR, '0, 4'd0, 32'h0);                           // clear, nothing live
    send_item(OP_ENTER, {64{1'b1}}, 4'd8, 32'hFFFF_FFFF);
    send_item(OP_ENTER, {64{1'b1}}, 4'd8, 32'h1234_5678);           // already present
    send_item(OP_REPLACE, {64{1'b1}}, 4'd8, 32'h0000_0000);
    send_item(OP_FIND, {64{1'b1}}, 4'd8, 32'h0);
    send_item(OP_RELEASE, {64{1'b1}}, 4'd8, 32'h0);
    send_item(OP_FIND, {64{1'b1}}, 4'd8, 32'h0);                    // released, miss
    send_item(OP_RELEASE, {64{1'b1}}, 4'd8, 32'h0);
    send_item(OP_ENTER, {64{1'b1}}, 4'd8, 32'hA5A5_5A5A);           // reuses the tombstone
    send_item(OP_ENTER, '0, 4'd0, 32'h0000_0001);                   // empty key, hash zero
    send_item(OP_ENTER, ONES_KEY, 4'd8, 32'h0BAD_F00D);             // hash of all ones
    send_item(OP_FIND, ONES_KEY, 4'd8, 32'h0);
    send_item(OP_ENTER, 64'h1122_3344_5566_7788, 4'd15, 32'h7);     // long length
    send_item(OP_FIND, 64'h1122_3344_5566_7788, 4'd8, 32'h0);
    send_item(OP_ENTER, 64'hDEAD_BEEF_0000_6162, 4'd3, 32'h3);      // bytes above length
    send_item(OP_FIND, 64'h0000_0000_0000_6162, 4'd3, 32'h0);       // zero byte inside key
    send_item(OP_FIND, 64'h0000_0000_0000_6162, 4'd2, 32'h0);       // shorter, no match
    send_item(3'd5, '0, 4'd0, 32'h0);
    send_item(3'd6, {64{1'b1}}, 4'd8, 32'hFFFF_FFFF);
    send_item(3'd7, '0, 4'd1, 32'h0);
    send_item(OP_CLEAR, '0, 4'd0, 32'h0);                           // clears live entries
    send_item(OP_FIND, ONES_KEY, 4'd8, 32'h0);

    // Back-pressure: the receiver holds off while the sender keeps offering,
    // so the output register fills and the block stalls its input.
    send_idle = 0;
    hold_asks <= hold_asks + 1;
    fill_pool(8);
    for (int i = 0; i < 8; i++) random_item();
    // Then the sender pauses until every result has come back.
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 3) begin
        send_idle = 25;
        recv_idle = 86;
      end else if (ph < 6) begin
        send_idle = 86;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph != 0) write_table_size(phase_size[ph]);
      fill_pool((phase_size[ph] < 64) ? 6 + phase_size[ph] % 18 : POOL_MAX);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
    end

    // Leave the table at its largest prime size with the register extremes done.
    write_table_size(10'd1021);
    fill_pool(POOL_MAX);
    for (int i = 0; i < 12; i++) random_item();

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("double_hash_key_table_tb: done, clean");
    end else begin
      $display("double_hash_key_table_tb: done, errors");
    end
    $finish;
  end

endmodule
